FILE: hw/rtl/rfrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrc_pkg
// Shared types and codes for the relay feedback retry controller.
// ----------------------------------------------------------------------------
package rfrc_pkg;

    // controller states
    localparam logic [2:0] ST_OFF      = 3'd0;
    localparam logic [2:0] ST_OFF_WAIT = 3'd1;
    localparam logic [2:0] ST_ON       = 3'd2;
    localparam logic [2:0] ST_ON_WAIT  = 3'd3;
    localparam logic [2:0] ST_ERROR    = 3'd4;

    // events seen by the state handler
    localparam logic [2:0] EV_REFRESH = 3'd0;
    localparam logic [2:0] EV_OFF     = 3'd1;
    localparam logic [2:0] EV_ON      = 3'd2;
    localparam logic [2:0] EV_CHECK   = 3'd3;
    localparam logic [2:0] EV_RETRY   = 3'd4;

    // request action codes
    localparam logic [1:0] ACT_REFRESH = 2'd0;
    localparam logic [1:0] ACT_OFF     = 2'd1;
    localparam logic [1:0] ACT_ON      = 2'd2;
    localparam logic [1:0] ACT_TICK    = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CHECKED_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_ENABLED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_EXPECTED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_DELAY_S  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAFETY_BYPASS     = 3'd5;
    localparam int unsigned CFG_DATA_W = 8;

    typedef struct packed {
        logic       checked_mode;
        logic       feedback_enabled;
        logic       feedback_expected;
        logic [7:0] feedback_delay_s;
        logic [7:0] max_attempts;
        logic       safety_bypass;
    } cfg_t;

    typedef struct packed {
        logic [2:0] fsm_state;
        logic [7:0] attempt_count;
        logic       relay_level;
        logic       exceeded_flag;
    } ctrl_t;

    // side effects requested by one handled event
    typedef struct packed {
        logic arm_check;
        logic arm_retry;
        logic start_timing;
        logic stop_timing;
    } hflags_t;

    typedef struct packed {
        logic [1:0] action;
        logic       safety_level;
        logic       heartbeat_missing;
        logic       feedback_level;
    } cmd_item_t;

    typedef struct packed {
        logic        relay_drive;
        logic        reported_on;
        logic [2:0]  ctrl_state;
        logic        attempts_exceeded;
        logic [31:0] work_seconds;
    } res_item_t;

endpackage

FILE: hw/rtl/rfrc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrc_cfg_regs
// Configuration register file, written one register per request.
// ----------------------------------------------------------------------------
module rfrc_cfg_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [rfrc_pkg::CFG_IDX_W-1:0]        wr_index,
    input  logic [rfrc_pkg::CFG_DATA_W-1:0]       wr_data,
    output rfrc_pkg::cfg_t                        cfg
);
    import rfrc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_CHECKED_MODE:      cfg_next.checked_mode      = wr_data[0];
                REG_FEEDBACK_ENABLED:  cfg_next.feedback_enabled  = wr_data[0];
                REG_FEEDBACK_EXPECTED: cfg_next.feedback_expected = wr_data[0];
                REG_FEEDBACK_DELAY_S:  cfg_next.feedback_delay_s  = wr_data;
                REG_MAX_ATTEMPTS:      cfg_next.max_attempts      = wr_data;
                REG_SAFETY_BYPASS:     cfg_next.safety_bypass     = wr_data[0];
                default:               cfg_next = cfg_reg; // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.checked_mode      <= 1'b0;
            cfg_reg.feedback_enabled  <= 1'b0;
            cfg_reg.feedback_expected <= 1'b1;
            cfg_reg.feedback_delay_s  <= 8'd1;
            cfg_reg.max_attempts      <= 8'd3;
            cfg_reg.safety_bypass     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/rfrc_handler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrc_handler
// Next-state logic of the controller for a single event.
// ----------------------------------------------------------------------------
module rfrc_handler
(
    input  logic                enable,
    input  logic [2:0]          ev,
    input  rfrc_pkg::cfg_t      cfg,
    input  logic                safety_level,
    input  logic                heartbeat_missing,
    input  logic                feedback_level,
    input  rfrc_pkg::ctrl_t     ctrl_in,
    output rfrc_pkg::ctrl_t     ctrl_out,
    output rfrc_pkg::hflags_t   flags
);
    import rfrc_pkg::*;

    logic       gate_ok;
    logic       feedback_ok;
    logic [8:0] attempt_inc;

    assign gate_ok     = !cfg.checked_mode
                         || ((safety_level || cfg.safety_bypass) && !heartbeat_missing);
    assign feedback_ok = (feedback_level == cfg.feedback_expected);
    assign attempt_inc = {1'b0, ctrl_in.attempt_count} + 9'd1;

    always_comb
    begin
        ctrl_out = ctrl_in;
        flags    = '0;
        if (enable)
        begin
            unique case (ctrl_in.fsm_state)
                ST_ON:
                begin
                    if (ev == EV_OFF)
                    begin
                        ctrl_out.relay_level = 1'b0;
                        flags.stop_timing    = 1'b1;
                        ctrl_out.fsm_state   = ST_OFF;
                    end
                    else if (ev == EV_REFRESH)
                    begin
                        if (!gate_ok)
                        begin
                            ctrl_out.relay_level = 1'b0;
                            flags.stop_timing    = 1'b1;
                            ctrl_out.fsm_state   = ST_ERROR;
                        end
                        else if (cfg.feedback_enabled && !feedback_ok)
                        begin
                            ctrl_out.relay_level = 1'b0;
                            flags.stop_timing    = 1'b1;
                            flags.arm_retry      = 1'b1;
                            ctrl_out.fsm_state   = ST_OFF_WAIT;
                        end
                    end
                end
                ST_ON_WAIT:
                begin
                    if (ev == EV_OFF || (ev == EV_REFRESH && !gate_ok))
                    begin
                        ctrl_out.relay_level = 1'b0;
                        ctrl_out.fsm_state   = ST_OFF;
                    end
                    else if (ev == EV_CHECK)
                    begin
                        if (feedback_ok)
                        begin
                            ctrl_out.attempt_count = 8'd0;
                            ctrl_out.fsm_state     = ST_ON;
                        end
                        else if (attempt_inc < {1'b0, cfg.max_attempts})
                        begin
                            ctrl_out.attempt_count = attempt_inc[7:0];
                            ctrl_out.relay_level   = 1'b0;
                            flags.arm_retry        = 1'b1;
                            ctrl_out.fsm_state     = ST_OFF_WAIT;
                        end
                        else
                        begin
                            ctrl_out.exceeded_flag = 1'b1;
                            ctrl_out.relay_level   = 1'b0;
                            ctrl_out.fsm_state     = ST_OFF;
                        end
                    end
                end
                ST_OFF_WAIT:
                begin
                    if (ev == EV_ON)
                    begin
                        ctrl_out.attempt_count = 8'd0;
                    end
                    else if (ev == EV_OFF || (ev == EV_REFRESH && !gate_ok))
                    begin
                        ctrl_out.fsm_state = ST_OFF;
                    end
                    else if (ev == EV_RETRY)
                    begin
                        ctrl_out.relay_level = 1'b1;
                        flags.arm_check      = 1'b1;
                        ctrl_out.fsm_state   = ST_ON_WAIT;
                    end
                end
                default:
                begin
                    // off, error and the unused codes share the turn-on path
                    if (ev == EV_OFF && ctrl_in.fsm_state != ST_OFF)
                    begin
                        ctrl_out.fsm_state = ST_OFF;
                    end
                    else if (ev == EV_ON
                             || (ev == EV_REFRESH && ctrl_in.fsm_state != ST_OFF))
                    begin
                        if (gate_ok)
                        begin
                            ctrl_out.relay_level   = 1'b1;
                            ctrl_out.exceeded_flag = 1'b0;
                            ctrl_out.fsm_state     = ST_ON;
                            if (cfg.checked_mode)
                            begin
                                flags.start_timing = 1'b1;
                                if (cfg.feedback_enabled)
                                begin
                                    flags.arm_check        = 1'b1;
                                    ctrl_out.attempt_count = 8'd0;
                                    ctrl_out.fsm_state     = ST_ON_WAIT;
                                end
                            end
                        end
                        else if (ctrl_in.fsm_state == ST_OFF)
                        begin
                            ctrl_out.fsm_state = ST_ERROR;
                        end
                    end
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/rfrc_worktime.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrc_worktime
// On-time counter; keeps the whole-second quotient alongside the tick count.
// ----------------------------------------------------------------------------
module rfrc_worktime
#(
    parameter int unsigned TICKS_PER_SECOND = 1000
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        update,
    input  logic        tick,
    input  logic        start,
    input  logic        stop,
    output logic [31:0] work_total_next
);
    localparam int unsigned SUB_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_SECOND - 1);

    logic             timing_active_reg, timing_active_next;
    logic [31:0]      elapsed_reg, elapsed_next;
    logic [SUB_W-1:0] sub_reg, sub_next;     // elapsed mod ticks per second
    logic [31:0]      sec_reg, sec_next;     // elapsed div ticks per second
    logic [31:0]      work_total_reg;

    always_comb
    begin
        timing_active_next = timing_active_reg;
        elapsed_next       = elapsed_reg;
        sub_next           = sub_reg;
        sec_next           = sec_reg;
        work_total_next    = work_total_reg;
        if (update)
        begin
            if (tick && timing_active_reg)
            begin
                elapsed_next = elapsed_reg + 32'd1;
                if (elapsed_reg == '1)
                begin
                    // count wraps to zero, so does the quotient
                    sub_next = '0;
                    sec_next = '0;
                end
                else if (sub_reg == SUB_LAST)
                begin
                    sub_next = '0;
                    sec_next = sec_reg + 32'd1;
                end
                else
                begin
                    sub_next = sub_reg + SUB_W'(1);
                end
            end
            if (start)
            begin
                timing_active_next = 1'b1;
                elapsed_next       = '0;
                sub_next           = '0;
                sec_next           = '0;
            end
            else if (stop && timing_active_reg)
            begin
                work_total_next    = work_total_reg + sec_reg;
                timing_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_active_reg <= 1'b0;
            elapsed_reg       <= '0;
            sub_reg           <= '0;
            sec_reg           <= '0;
            work_total_reg    <= '0;
        end
        else
        begin
            timing_active_reg <= timing_active_next;
            elapsed_reg       <= elapsed_next;
            sub_reg           <= sub_next;
            sec_reg           <= sec_next;
            work_total_reg    <= work_total_next;
        end
    end

endmodule

FILE: hw/rtl/relay_feedback_retry_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_feedback_retry_controller
// Relay coil controller with safety gating, feedback check and retries.
// ----------------------------------------------------------------------------
// One request (on, off, refresh or a millisecond tick) is taken per clock
// while the request side is not stalled, and its result is in the result
// register on the next cycle; the only thing that holds the request side
// back is a result still held under res_stall. A tick may fire
// the feedback check and then the retry event in the same cycle: the two are
// handled by two chained copies of the state logic. The on-time counter keeps
// the whole-second quotient incrementally, so no divider is needed. Config
// writes are always ready and should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module relay_feedback_retry_controller
#(
    parameter int unsigned TICKS_PER_SECOND = 1000
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  rfrc_pkg::cmd_item_t               cmd,
    // result channel
    output logic                              res_valid,
    input  logic                              res_stall,
    output rfrc_pkg::res_item_t               res,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rfrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rfrc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rfrc_pkg::*;

    // timers hold up to 255 seconds of ticks
    localparam int unsigned TMR_W = $clog2(255 * TICKS_PER_SECOND + 1);
    localparam logic [TMR_W-1:0] DELAY_SCALE = TMR_W'(TICKS_PER_SECOND);

    cfg_t cfg;

    logic accept;
    logic tick;

    // controller and timer state
    ctrl_t            ctrl_reg, ctrl_next;
    logic             check_pending_reg, check_pending_next;
    logic [TMR_W-1:0] check_rem_reg, check_rem_next;
    logic             retry_pending_reg, retry_pending_next;
    logic [TMR_W-1:0] retry_rem_reg, retry_rem_next;

    // result register
    logic      res_valid_reg, res_valid_next;
    res_item_t res_reg, res_next;

    // combinational tick path through the two chained handlers
    logic [TMR_W-1:0] delay_ticks;
    logic [TMR_W-1:0] check_dec, retry_dec;
    logic             fire_check, fire_retry;
    logic             check_pending_a, retry_pending_a;
    logic [TMR_W-1:0] check_rem_a, retry_rem_a;
    logic [2:0]       ev_a;
    ctrl_t            ctrl_a;
    hflags_t          flags_a, flags_b;
    logic [31:0]      work_total_next;

    assign cfg_ready = 1'b1;
    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign tick      = (cmd.action == ACT_TICK);

    rfrc_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign delay_ticks = TMR_W'(cfg.feedback_delay_s) * DELAY_SCALE;

    // both counts drop first, then the check fires before the retry
    always_comb
    begin
        check_dec = check_rem_reg;
        retry_dec = retry_rem_reg;
        if (tick && check_pending_reg && check_rem_reg != '0)
        begin
            check_dec = check_rem_reg - TMR_W'(1);
        end
        if (tick && retry_pending_reg && retry_rem_reg != '0)
        begin
            retry_dec = retry_rem_reg - TMR_W'(1);
        end
    end

    assign fire_check = tick && check_pending_reg && (check_dec == '0);
    assign ev_a       = tick ? EV_CHECK : {1'b0, cmd.action};

    rfrc_handler u_handler_a
    (
        .enable            (!tick || fire_check),
        .ev                (ev_a),
        .cfg               (cfg),
        .safety_level      (cmd.safety_level),
        .heartbeat_missing (cmd.heartbeat_missing),
        .feedback_level    (cmd.feedback_level),
        .ctrl_in           (ctrl_reg),
        .ctrl_out          (ctrl_a),
        .flags             (flags_a)
    );

    always_comb
    begin
        check_pending_a = fire_check ? 1'b0 : check_pending_reg;
        check_rem_a     = check_dec;
        retry_pending_a = retry_pending_reg;
        retry_rem_a     = retry_dec;
        if (flags_a.arm_check)
        begin
            check_pending_a = 1'b1;
            check_rem_a     = delay_ticks;
        end
        if (flags_a.arm_retry)
        begin
            retry_pending_a = 1'b1;
            retry_rem_a     = delay_ticks;
        end
    end

    // a retry armed by the check with zero delay fires in the same tick
    assign fire_retry = tick && retry_pending_a && (retry_rem_a == '0);

    rfrc_handler u_handler_b
    (
        .enable            (fire_retry),
        .ev                (EV_RETRY),
        .cfg               (cfg),
        .safety_level      (cmd.safety_level),
        .heartbeat_missing (cmd.heartbeat_missing),
        .feedback_level    (cmd.feedback_level),
        .ctrl_in           (ctrl_a),
        .ctrl_out          (ctrl_next),
        .flags             (flags_b)
    );

    always_comb
    begin
        check_pending_next = check_pending_a;
        check_rem_next     = check_rem_a;
        retry_pending_next = fire_retry ? 1'b0 : retry_pending_a;
        retry_rem_next     = retry_rem_a;
        if (flags_b.arm_check)
        begin
            check_pending_next = 1'b1;
            check_rem_next     = delay_ticks;
        end
        if (flags_b.arm_retry)
        begin
            retry_pending_next = 1'b1;
            retry_rem_next     = delay_ticks;
        end
    end

    rfrc_worktime
    #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    )
    u_worktime
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .update          (accept),
        .tick            (tick),
        .start           (flags_a.start_timing || flags_b.start_timing),
        .stop            (flags_a.stop_timing || flags_b.stop_timing),
        .work_total_next (work_total_next)
    );

    always_comb
    begin
        res_next.relay_drive       = ctrl_next.relay_level;
        res_next.reported_on       = (ctrl_next.fsm_state != ST_OFF);
        res_next.ctrl_state        = ctrl_next.fsm_state;
        res_next.attempts_exceeded = ctrl_next.exceeded_flag;
        res_next.work_seconds      = work_total_next;
    end

    // result slot frees when taken; a new request may refill it in that cycle
    assign res_valid_next = accept || (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.fsm_state     <= ST_OFF;
            ctrl_reg.attempt_count <= '0;
            ctrl_reg.relay_level   <= 1'b0;
            ctrl_reg.exceeded_flag <= 1'b0;
            check_pending_reg      <= 1'b0;
            check_rem_reg          <= '0;
            retry_pending_reg      <= 1'b0;
            retry_rem_reg          <= '0;
            res_valid_reg          <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                ctrl_reg          <= ctrl_next;
                check_pending_reg <= check_pending_next;
                check_rem_reg     <= check_rem_next;
                retry_pending_reg <= retry_pending_next;
                retry_rem_reg     <= retry_rem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef ASSERT_OFF
    // coil is driven exactly in the two on states
    a_relay_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.relay_level == (ctrl_reg.fsm_state == ST_ON
                                 || ctrl_reg.fsm_state == ST_ON_WAIT))
        else $error("relay level disagrees with controller state");

    // give-up flag only appears on the way to off
    a_exceeded_goes_off: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ctrl_reg.exceeded_flag) |-> ctrl_reg.fsm_state == ST_OFF)
        else $error("attempts flag set outside off state");

    // every accepted request leaves a result behind
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg)
        else $error("accepted request produced no result");

    // request side is only held back by a pending result
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> res_valid_reg && res_stall)
        else $error("request stalled without a held result");
`endif

endmodule
